// ----- rtl/clock_replacement_sector_cache_macros.svh -----
// Assertion macros shared by the sector cache RTL.
`ifndef CLOCK_REPLACEMENT_SECTOR_CACHE_MACROS_SVH
`define CLOCK_REPLACEMENT_SECTOR_CACHE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define CRSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds on a rising edge outside reset.
`define CRSC_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRSC_ASSERT(label, clk, rst_n, prop, msg)
`define CRSC_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/crsc_pkg.sv -----
// Shared constants and types of the clock replacement sector cache.
package crsc_pkg;

    localparam int ENTRIES     = 64;
    localparam int SECTOR_BITS = 32;
    localparam int SECTOR_W    = 32;
    localparam int SLOT_W      = 6;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TAG_W       = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACCESS     = 2'd0,
        KIND_FLUSH_WB   = 2'd1,
        KIND_FLUSH_NONE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic [SECTOR_W-1:0] sector;
    } req_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                writeback;
        logic [SECTOR_W-1:0] writeback_sector;
        logic                last;
    } rsp_item_t;

    typedef struct packed {
        logic             is_flush;
        logic             is_write;
        logic [TAG_W-1:0] tag;
    } cmd_t;

endpackage

// ----- rtl/crsc_front.sv -----
// Request intake: decode, drop unused codes and queue commands for the engine.
`include "clock_replacement_sector_cache_macros.svh"
module crsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  crsc_pkg::req_item_t req,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output crsc_pkg::cmd_t      cmd
);

    localparam int PW = crsc_pkg::QPTR_W;
    localparam int CW = crsc_pkg::QCNT_W;

    crsc_pkg::cmd_t q_reg [crsc_pkg::QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;

    crsc_pkg::cmd_t decoded;
    logic           keep;
    logic           push;
    logic           pop;

    always_comb
    begin
        decoded.tag      = req.sector[crsc_pkg::TAG_W-1:0];
        decoded.is_flush = 1'b0;
        decoded.is_write = 1'b0;
        keep             = 1'b1;
        unique case (req.operation)
            crsc_pkg::OP_READ:
            begin
                keep = 1'b1;
            end
            crsc_pkg::OP_WRITE:
            begin
                decoded.is_write = 1'b1;
            end
            crsc_pkg::OP_FLUSH:
            begin
                decoded.is_flush = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req_ready = (cnt_reg != CW'(crsc_pkg::QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(crsc_pkg::QDEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(crsc_pkg::QDEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `CRSC_NEVER(q_overflow, clk, rst_n, push && !pop && cnt_reg == CW'(crsc_pkg::QDEPTH), "queue overflow")
    `CRSC_ASSERT(q_empty_ptrs, clk, rst_n, cnt_reg == '0 |-> wr_ptr_reg == rd_ptr_reg, "empty queue with split pointers")

endmodule

// ----- rtl/crsc_back.sv -----
// Cache engine: tag scan, clock sweep, victim claim and flush walk.
`include "clock_replacement_sector_cache_macros.svh"
module crsc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  crsc_pkg::cmd_t      cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output crsc_pkg::rsp_item_t rsp
);

    localparam int IW = crsc_pkg::IDX_W;
    localparam int TW = crsc_pkg::TAG_W;
    localparam int N  = crsc_pkg::ENTRIES;
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_HIT,
        ST_SWEEP,
        ST_VICTIM,
        ST_FLUSH,
        ST_FLUSH_RD,
        ST_FLUSH_END
    } state_t;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // Tag memory: one write and one registered read port
    logic [TW-1:0] tag_mem [N];
    logic [TW-1:0] rdata_reg;
    logic          mem_we;

    state_t              state_reg;
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic                primed_reg;
    logic [TW-1:0]       tag_reg;
    logic                write_reg;
    logic [IW-1:0]       slot_reg;
    logic [IW-1:0]       hand_reg;
    logic [N-1:0]        valid_reg;
    logic [N-1:0]        dirty_reg;
    logic [N-1:0]        accessed_reg;
    logic                pend_reg;
    logic [IW-1:0]       pend_idx_reg;
    logic [TW-1:0]       pend_tag_reg;
    crsc_pkg::rsp_item_t rsp_reg;
    logic                rsp_valid_reg;

    logic                can_emit;
    logic                emit;
    logic                match;
    logic                sweep_pass;
    logic                victim_wb;
    logic                flush_go;
    crsc_pkg::rsp_item_t res;

    assign can_emit   = !rsp_valid_reg || rsp_ready;
    assign match      = primed_reg && valid_reg[rd_idx_reg] && (rdata_reg == tag_reg);
    assign sweep_pass = valid_reg[idx_reg] && accessed_reg[idx_reg];
    assign victim_wb  = valid_reg[idx_reg] && dirty_reg[idx_reg];
    assign flush_go   = !pend_reg || can_emit;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign mem_we     = (state_reg == ST_VICTIM) && can_emit;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[idx_reg] <= tag_reg;
        end
        rdata_reg <= tag_mem[idx_reg];
    end

    always_comb
    begin
        emit                 = 1'b0;
        res                  = '0;
        res.kind             = crsc_pkg::KIND_ACCESS;
        unique case (state_reg)
            ST_HIT:
            begin
                emit     = can_emit;
                res.slot = crsc_pkg::SLOT_W'(slot_reg);
                res.hit  = 1'b1;
                res.last = 1'b1;
            end
            ST_VICTIM:
            begin
                emit          = can_emit;
                res.slot      = crsc_pkg::SLOT_W'(idx_reg);
                res.writeback = victim_wb;
                res.writeback_sector = victim_wb ? crsc_pkg::SECTOR_W'(rdata_reg) : '0;
                res.last      = 1'b1;
            end
            ST_FLUSH_RD:
            begin
                emit          = pend_reg && can_emit;
                res.kind      = crsc_pkg::KIND_FLUSH_WB;
                res.slot      = crsc_pkg::SLOT_W'(pend_idx_reg);
                res.writeback = 1'b1;
                res.writeback_sector = crsc_pkg::SECTOR_W'(pend_tag_reg);
            end
            ST_FLUSH_END:
            begin
                emit     = can_emit;
                res.last = 1'b1;
                if (pend_reg)
                begin
                    res.kind      = crsc_pkg::KIND_FLUSH_WB;
                    res.slot      = crsc_pkg::SLOT_W'(pend_idx_reg);
                    res.writeback = 1'b1;
                    res.writeback_sector = crsc_pkg::SECTOR_W'(pend_tag_reg);
                end
                else
                begin
                    res.kind = crsc_pkg::KIND_FLUSH_NONE;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rd_idx_reg    <= '0;
            primed_reg    <= 1'b0;
            tag_reg       <= '0;
            write_reg     <= 1'b0;
            slot_reg      <= '0;
            hand_reg      <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            accessed_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            pend_tag_reg  <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= idx_reg;
            primed_reg <= (state_reg == ST_LOOKUP);

            if (emit)
            begin
                rsp_reg       <= res;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        tag_reg   <= cmd.tag;
                        write_reg <= cmd.is_write;
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= cmd.is_flush ? ST_FLUSH : ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    // Issue one tag read a cycle, compare the one read last cycle
                    if (match)
                    begin
                        slot_reg  <= rd_idx_reg;
                        state_reg <= ST_HIT;
                    end
                    else if (primed_reg && rd_idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= hand_reg;
                        state_reg <= ST_SWEEP;
                    end
                    else
                    begin
                        idx_reg <= (idx_reg == LAST_IDX) ? idx_reg : idx_reg + 1'b1;
                    end
                end
                ST_HIT:
                begin
                    if (can_emit)
                    begin
                        accessed_reg[slot_reg] <= 1'b1;
                        if (write_reg)
                        begin
                            dirty_reg[slot_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SWEEP:
                begin
                    if (sweep_pass)
                    begin
                        accessed_reg[idx_reg] <= 1'b0;
                        idx_reg               <= next_idx(idx_reg);
                    end
                    else
                    begin
                        state_reg <= ST_VICTIM;
                    end
                end
                ST_VICTIM:
                begin
                    if (can_emit)
                    begin
                        valid_reg[idx_reg]    <= 1'b1;
                        dirty_reg[idx_reg]    <= write_reg;
                        accessed_reg[idx_reg] <= 1'b1;
                        hand_reg              <= next_idx(idx_reg);
                        state_reg             <= ST_IDLE;
                    end
                end
                ST_FLUSH:
                begin
                    if (victim_wb)
                    begin
                        state_reg <= ST_FLUSH_RD;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_FLUSH_END;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_FLUSH_RD:
                begin
                    // Hold one write-back back so the final one can carry last
                    if (flush_go)
                    begin
                        pend_reg           <= 1'b1;
                        pend_idx_reg       <= idx_reg;
                        pend_tag_reg       <= rdata_reg;
                        dirty_reg[idx_reg] <= 1'b0;
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_FLUSH_END;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH_END:
                begin
                    if (can_emit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `CRSC_NEVER(hand_range, clk, rst_n, hand_reg > LAST_IDX, "hand beyond last entry")
    `CRSC_ASSERT(victim_unmarked, clk, rst_n, state_reg == ST_VICTIM |-> !(valid_reg[idx_reg] && accessed_reg[idx_reg]), "victim still carries accessed mark")
    `CRSC_NEVER(rsp_overrun, clk, rst_n, emit && rsp_valid_reg && !rsp_ready, "result overwrites unaccepted result")
    `CRSC_ASSERT(hit_no_wb, clk, rst_n, rsp_valid_reg && rsp_reg.hit |-> !rsp_reg.writeback, "hit reports a write-back")

endmodule

// ----- rtl/clock_replacement_sector_cache.sv -----
// Top level of the clock (second-chance) replacement sector cache controller.
//
// Usage: present one request at a time on req (operation, sector) with
// req_valid; it is taken on a cycle with req_valid and req_ready high.
// Results leave on rsp with rsp_valid; take them with rsp_ready.
// A read or write gives one result (kind access); a flush gives one
// write-back result per dirty entry in index order, or a single
// "nothing dirty" result; the final result of a request has last set.
// Operation code 3 is dropped at intake and gives no result.
// Throughput: the engine handles one request at a time; intake queues up
// to two requests ahead of it. The single read port of the tag memory sets
// the pace.
// Reset: all valid, dirty and accessed marks clear, hand at entry 0, the
// queue empties; no clearing pass is needed, tags are only read when valid.
// Stalls: a result waits in the output register while rsp_ready is low and
// the engine holds; intake keeps taking requests until its queue is full.
module clock_replacement_sector_cache (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  crsc_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output crsc_pkg::rsp_item_t rsp
);

    crsc_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_ready;

    // Decode and queue requests
    crsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Carry out lookups, replacements and flushes
    crsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- sim/crsc_outcome_checker.sv -----
// Request/result monitor with a clock-replacement cache predictor for the sector cache.
`timescale 1ns / 100ps

module crsc_outcome_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  crsc_pkg::req_item_t req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  crsc_pkg::rsp_item_t rsp,
    output int                  errors,
    output int                  outstanding,
    output int                  hits,
    output int                  fills,
    output int                  dirty_evictions,
    output int                  flushed_entries,
    output int                  clean_flushes
);

    import crsc_pkg::*;

    // Predicted cache metadata
    logic [TAG_W-1:0]   tag_of [ENTRIES];
    logic [ENTRIES-1:0] valid_bits;
    logic [ENTRIES-1:0] dirty_bits;
    logic [ENTRIES-1:0] accessed_bits;
    logic [SLOT_W-1:0]  hand_pos;

    rsp_item_t cache_outcomes[$];
    rsp_item_t due;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h",
                     $time, what, got, want);
            errors++;
        end
    endtask

    // Apply one accepted request to the predicted metadata and queue its outcomes.
    task automatic run_clock_policy(input req_item_t r);
        rsp_item_t        o;
        logic [TAG_W-1:0] key;
        int               slot_idx;
        int               h;
        int               steps;
        int               left;
        bit               found;
        begin
            key      = r.sector[TAG_W-1:0];
            o        = '0;
            found    = 1'b0;
            slot_idx = 0;
            case (r.operation)
                OP_FLUSH:
                begin
                    left = $countones(valid_bits & dirty_bits);
                    if (left == 0)
                    begin
                        o.kind = KIND_FLUSH_NONE;
                        o.last = 1'b1;
                        cache_outcomes.push_back(o);
                        clean_flushes++;
                    end
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid_bits[i] && dirty_bits[i])
                        begin
                            left--;
                            o.kind             = KIND_FLUSH_WB;
                            o.slot             = SLOT_W'(i);
                            o.hit              = 1'b0;
                            o.writeback        = 1'b1;
                            o.writeback_sector = SECTOR_W'(tag_of[i]);
                            o.last             = (left == 0);
                            dirty_bits[i]      = 1'b0;
                            cache_outcomes.push_back(o);
                            flushed_entries++;
                        end
                    end
                end
                OP_READ, OP_WRITE:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!found && valid_bits[i] && tag_of[i] == key)
                        begin
                            found    = 1'b1;
                            slot_idx = i;
                        end
                    end
                    o.kind = KIND_ACCESS;
                    o.last = 1'b1;
                    if (found)
                    begin
                        accessed_bits[slot_idx] = 1'b1;
                        o.hit = 1'b1;
                        hits++;
                    end
                    else
                    begin
                        // Sweep: strip second chances until an unmarked or empty entry.
                        h     = hand_pos;
                        steps = 0;
                        while (steps < 2 * ENTRIES && valid_bits[h] && accessed_bits[h])
                        begin
                            accessed_bits[h] = 1'b0;
                            h = (h + 1) % ENTRIES;
                            steps++;
                        end
                        slot_idx = h;
                        if (valid_bits[slot_idx] && dirty_bits[slot_idx])
                        begin
                            o.writeback        = 1'b1;
                            o.writeback_sector = SECTOR_W'(tag_of[slot_idx]);
                            dirty_evictions++;
                        end
                        valid_bits[slot_idx]    = 1'b1;
                        tag_of[slot_idx]        = key;
                        dirty_bits[slot_idx]    = 1'b0;
                        accessed_bits[slot_idx] = 1'b1;
                        hand_pos = SLOT_W'((slot_idx + 1) % ENTRIES);
                        fills++;
                    end
                    if (r.operation == OP_WRITE)
                        dirty_bits[slot_idx] = 1'b1;
                    o.slot = SLOT_W'(slot_idx);
                    cache_outcomes.push_back(o);
                end
                default:
                begin
                    // Unused code: dropped at intake, nothing changes.
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits      = '0;
            dirty_bits      = '0;
            accessed_bits   = '0;
            hand_pos        = '0;
            errors          = 0;
            hits            = 0;
            fills           = 0;
            dirty_evictions = 0;
            flushed_entries = 0;
            clean_flushes   = 0;
            cache_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                run_clock_policy(req);
            if (rsp_valid && rsp_ready)
            begin
                if (cache_outcomes.size() == 0)
                    report_mismatch("unexpected result, slot", 32'(rsp.slot), 32'd0);
                else
                begin
                    due = cache_outcomes.pop_front();
                    if (rsp.kind !== due.kind)
                        report_mismatch("kind", 32'(rsp.kind), 32'(due.kind));
                    if (rsp.slot !== due.slot)
                        report_mismatch("slot", 32'(rsp.slot), 32'(due.slot));
                    if (rsp.hit !== due.hit)
                        report_mismatch("hit", 32'(rsp.hit), 32'(due.hit));
                    if (rsp.writeback !== due.writeback)
                        report_mismatch("writeback", 32'(rsp.writeback), 32'(due.writeback));
                    if (rsp.writeback_sector !== due.writeback_sector)
                        report_mismatch("writeback_sector", rsp.writeback_sector,
                                        due.writeback_sector);
                    if (rsp.last !== due.last)
                        report_mismatch("last", 32'(rsp.last), 32'(due.last));
                end
            end
            outstanding <= cache_outcomes.size();
        end
    end

endmodule

// ----- sim/tb_clock_replacement_sector_cache.sv -----
// Top of the sector cache testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 100ps

module tb_clock_replacement_sector_cache;

    import crsc_pkg::*;

    // Operation code 3 has no member in the package; the block drops it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int POOL_SIZE    = 80;
    localparam int HOT_SIZE     = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4 * ENTRIES;
    localparam int CYCLE_LIMIT  = 600000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    int errors;
    int outstanding;
    int hits;
    int fills;
    int dirty_evictions;
    int flushed_entries;
    int clean_flushes;

    // Traffic shaping and counts; cycle_count is kept by the watchdog, the rest by the main sequence
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_wanted;
    int cycle_count;
    int issued;
    int dropped;

    logic [31:0] sector_pool [POOL_SIZE];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    clock_replacement_sector_cache u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    crsc_outcome_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .errors          (errors),
        .outstanding     (outstanding),
        .hits            (hits),
        .fills           (fills),
        .dirty_evictions (dirty_evictions),
        .flushed_entries (flushed_entries),
        .clean_flushes   (clean_flushes)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
            $display("tb_clock_replacement_sector_cache: FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off when asked.
    // The hold is counted here so only this process drives rsp_ready.
    initial
    begin : result_sink
        int  held;
        bit  hold_done;
        held      = 0;
        hold_done = 1'b0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_done)
            begin
                rsp_ready <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one request: idle first at the sender's rate, then hold valid and
    // the payload steady until the block takes it. Valid stays high on exit so
    // a back-to-back request never sees valid drop and rise in one step.
    task automatic offer_request(input logic [1:0] op, input logic [31:0] sec);
        req_item_t item;
        begin
            item.operation = op;
            item.sector    = sec;
            while ($urandom_range(99) < tx_idle_pct)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
            req_valid <= 1'b1;
            req       <= item;
            do
                @(posedge clk);
            while (!req_ready);
            if (op == OP_UNUSED)
                dropped++;
            else
                issued++;
        end
    endtask

    // Mostly accesses over a bounded working set, so the cache fills, hits
    // recur and dirty victims get evicted; some fully random sectors as noise.
    task automatic offer_random_request();
        int          pick;
        logic [1:0]  op;
        logic [31:0] sec;
        begin
            pick = $urandom_range(99);
            if (pick < 42)
                op = OP_READ;
            else if (pick < 84)
                op = OP_WRITE;
            else if (pick < 94)
                op = OP_FLUSH;
            else
                op = OP_UNUSED;
            pick = $urandom_range(99);
            if (pick < 15)
                sec = sector_pool[$urandom_range(HOT_SIZE - 1)];
            else if (pick < 80)
                sec = sector_pool[$urandom_range(POOL_SIZE - 1)];
            else
                sec = $urandom;
            offer_request(op, sec);
        end
    endtask

    // Release valid and wait until every predicted result has been taken.
    task automatic drain_results();
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while (outstanding != 0);
        end
    endtask

    initial
    begin : main_sequence
        int target;
        issued      = 0;
        dropped     = 0;
        hold_wanted = 1'b0;
        tx_idle_pct = 16;
        rx_idle_pct = 51;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        // Edge sectors at the head of the pool so they recur in the random part.
        sector_pool[0] = 32'h0000_0000;
        sector_pool[1] = 32'hFFFF_FFFF;
        sector_pool[2] = 32'h8000_0000;
        sector_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++)
            sector_pool[i] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty flush, misses into fresh entries, hits, dropped
        // code, flush of dirty entries, flush again with nothing dirty.
        offer_request(OP_FLUSH, 32'h0000_0000);
        offer_request(OP_READ,  32'h0000_0000);
        offer_request(OP_WRITE, 32'hFFFF_FFFF);
        offer_request(OP_READ,  32'hFFFF_FFFF);
        offer_request(OP_WRITE, 32'h0000_0000);
        offer_request(OP_UNUSED, 32'hDEAD_BEEF);
        offer_request(OP_UNUSED, 32'hFFFF_FFFF);
        offer_request(OP_FLUSH, 32'hFFFF_FFFF);
        offer_request(OP_FLUSH, 32'h1234_5678);
        offer_request(OP_WRITE, 32'h8000_0000);
        offer_request(OP_WRITE, 32'h0000_0001);
        offer_request(OP_READ,  32'h7FFF_FFFE);
        offer_request(OP_WRITE, 32'hAAAA_AAAA);
        offer_request(OP_WRITE, 32'h5555_5555);
        offer_request(OP_READ,  32'h8000_0000);
        offer_request(OP_READ,  32'h0000_0001);
        offer_request(OP_FLUSH, 32'h0000_0000);
        offer_request(OP_READ,  32'hAAAA_AAAA);
        offer_request(OP_FLUSH, 32'h0000_0000);

        // Sender idles lightly, receiver heavily.
        target = issued + 70;
        while (issued < target)
            offer_random_request();
        drain_results();

        // Swap the idling rates.
        tx_idle_pct = 51;
        rx_idle_pct = 16;
        target = issued + 70;
        while (issued < target)
            offer_random_request();
        drain_results();

        // Full rate both sides, opening with a long receiver hold-off so the
        // intake queue fills and req_ready drops while requests keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_wanted = 1'b1;
        target = issued + 60;
        while (issued < target)
            offer_random_request();
        drain_results();

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d dropped codes): %0d hits, %0d fills, %0d dirty %s",
                 issued, dropped, hits, fills, dirty_evictions, "evictions");
        $display("flushes wrote back %0d entries, %0d flushes found nothing dirty, %0d cycles",
                 flushed_entries, clean_flushes, cycle_count);
        if (errors == 0)
            $display("tb_clock_replacement_sector_cache: PASS");
        else
            $display("tb_clock_replacement_sector_cache: FAIL");
        $finish;
    end

endmodule
